[rtl/lp2p_pkg.sv]
// Shared types and constants for the lidar point to pixel projection block.
package lp2p_pkg;

	localparam int PT_W      = 20;               // point coordinate width
	localparam int X_W       = PT_W - 1;         // kept x is never negative
	localparam int COEF_W    = 32;               // Q16.16 matrix entry
	localparam int CFG_W     = 64;               // widest register
	localparam int RANGE_W   = 19;
	localparam int PROD_W    = COEF_W + PT_W;    // one product
	localparam int PSUM_W    = PROD_W + 1;       // sum of two products
	localparam int ROW_W     = PROD_W + 2;       // full row value
	localparam int DEN_W     = ROW_W - 1;        // positive depth
	localparam int DIV_STEPS = 16;               // quotient bits for u and v
	localparam int COL_STEPS = 8;                // quotient bits for colour
	localparam int CMP_W     = ROW_W + DIV_STEPS;
	localparam int G_W       = X_W + COL_STEPS;  // 255*x
	localparam int GCMP_W    = G_W + 1;
	localparam int NUM_COEF  = 6;
	localparam int METRE_SH  = 10;               // one metre is 1024 units

	localparam logic [RANGE_W-1:0] RANGE_RESET = 19'd61440;
	localparam logic signed [15:0] PIX_MAX = 16'sh7fff;
	localparam logic signed [15:0] PIX_MIN = 16'sh8000;
	localparam logic [7:0] COL_FULL = 8'd255;

	typedef enum logic [2:0] {
		REG_ROW0_01   = 3'd0,
		REG_ROW0_23   = 3'd1,
		REG_ROW1_01   = 3'd2,
		REG_ROW1_23   = 3'd3,
		REG_ROW2_01   = 3'd4,
		REG_ROW2_23   = 3'd5,
		REG_MAX_RANGE = 3'd6
	} reg_idx_t;

	typedef logic [NUM_COEF-1:0][CFG_W-1:0] coef_set_t;

	// Row values of one kept point, leaving the matrix stages.
	typedef struct packed {
		logic signed [ROW_W-1:0] y0;
		logic signed [ROW_W-1:0] y1;
		logic signed [ROW_W-1:0] y2;
		logic [X_W-1:0]          x;
	} row_word_t;

	// Divider state carried down the division stages.
	typedef struct packed {
		logic                  neg_u;
		logic                  neg_v;
		logic                  ovf_u;
		logic                  ovf_v;
		logic [ROW_W-1:0]      rem_u;
		logic [ROW_W-1:0]      rem_v;
		logic [DEN_W-1:0]      den;
		logic [DIV_STEPS-1:0]  q_u;
		logic [DIV_STEPS-1:0]  q_v;
		logic [G_W-1:0]        grem;
		logic [COL_STEPS-1:0]  gq;
		logic                  rzero;
	} div_word_t;

endpackage

[rtl/lp2p_rows.sv]
// Matrix stages: products, pair sums, row sums with range and depth checks.
module lp2p_rows import lp2p_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     pt_valid,
	output logic                     take,
	input  logic signed [PT_W-1:0]   px,
	input  logic signed [PT_W-1:0]   py,
	input  logic signed [PT_W-1:0]   pz,
	input  coef_set_t                coef,
	input  logic [RANGE_W-1:0]       range,
	output logic                     row_valid,
	output row_word_t                row,
	input  logic                     row_take
);

	logic signed [PT_W-1:0]   pt [3];
	logic                     keep;
	logic                     adv1, adv2, adv3;

	logic                     vld_s1, vld_s2, vld_s3;
	logic signed [PROD_W-1:0] prod_s1 [3][4];
	logic [X_W-1:0]           x_s1, x_s2;
	logic signed [PSUM_W-1:0] psum_s2 [3][2];
	logic signed [ROW_W-1:0]  ysum [3];
	row_word_t                row_s3;

	assign pt[0] = px;
	assign pt[1] = py;
	assign pt[2] = pz;

	assign keep = !px[PT_W-1] && (px[X_W-1:0] <= range);

	assign adv3 = !vld_s3 || row_take;
	assign adv2 = !vld_s2 || adv3;
	assign adv1 = !vld_s1 || adv2;
	assign take = adv1;

	// stage 1: twelve products, constant column is a shift
	for (genvar r = 0; r < 3; r++) begin : g_row
		for (genvar i = 0; i < 4; i++) begin : g_col
			logic signed [COEF_W-1:0] c;
			assign c = coef[2*r + i/2][COEF_W*(i%2) +: COEF_W];
			if (i < 3) begin : g_mul
				always_ff @(posedge clk) begin
					if (adv1) prod_s1[r][i] <= PROD_W'(c) * PROD_W'(pt[i]);
				end
			end else begin : g_off
				always_ff @(posedge clk) begin
					if (adv1)
						prod_s1[r][i] <= {{(PROD_W-COEF_W-METRE_SH){c[COEF_W-1]}},
							c, {METRE_SH{1'b0}}};
				end
			end
		end
		// stage 2: pair sums
		always_ff @(posedge clk) begin
			if (adv2) begin
				psum_s2[r][0] <= PSUM_W'(prod_s1[r][0]) + PSUM_W'(prod_s1[r][1]);
				psum_s2[r][1] <= PSUM_W'(prod_s1[r][2]) + PSUM_W'(prod_s1[r][3]);
			end
		end
		assign ysum[r] = ROW_W'(psum_s2[r][0]) + ROW_W'(psum_s2[r][1]);
	end

	always_ff @(posedge clk) begin
		if (adv1) x_s1 <= px[X_W-1:0];
		if (adv2) x_s2 <= x_s1;
		if (adv3) begin
			row_s3.y0 <= ysum[0];
			row_s3.y1 <= ysum[1];
			row_s3.y2 <= ysum[2];
			row_s3.x  <= x_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= pt_valid && keep;
			if (adv2) vld_s2 <= vld_s1;
			// stage 3 drops points with non-positive depth
			if (adv3) vld_s3 <= vld_s2 && (ysum[2] > 0);
		end
	end

	assign row_valid = vld_s3;
	assign row       = row_s3;

endmodule

[rtl/lp2p_div.sv]
// Division stages: one quotient bit per stage, then saturation and colour.
module lp2p_div import lp2p_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     row_valid,
	input  row_word_t                row,
	output logic                     row_take,
	input  logic [RANGE_W-1:0]       range,
	output logic                     pix_valid,
	input  logic                     pix_stall,
	output logic signed [15:0]       pix_u,
	output logic signed [15:0]       pix_v,
	output logic [7:0]               pix_red,
	output logic [7:0]               pix_green
);

	function automatic logic signed [15:0] sat_q(input logic neg, input logic ovf,
		input logic [DIV_STEPS-1:0] q);
		logic signed [15:0] r;
		begin
			if (ovf) r = neg ? PIX_MIN : PIX_MAX;
			else if (!neg) r = q[DIV_STEPS-1] ? PIX_MAX : signed'(q);
			else r = (q > 16'd32768) ? PIX_MIN : signed'(-q);
			return r;
		end
	endfunction

	logic [DIV_STEPS+1:0]  adv;
	logic [DIV_STEPS:0]    vld_s;
	div_word_t             dw_s [0:DIV_STEPS];
	div_word_t             init;
	logic [ROW_W-1:0]      mag_u, mag_v;
	logic [DEN_W-1:0]      den;

	logic                  ovld_q;
	logic signed [15:0]    u_q, v_q;
	logic [7:0]            red_q, green_q;

	assign adv[DIV_STEPS+1] = !ovld_q || !pix_stall;
	for (genvar j = 0; j <= DIV_STEPS; j++) begin : g_adv
		assign adv[j] = !vld_s[j] || adv[j+1];
	end
	assign row_take = adv[0];

	// setup stage: magnitudes, overflow check, 255*x
	always_comb begin
		mag_u = row.y0[ROW_W-1] ? ROW_W'(-row.y0) : ROW_W'(row.y0);
		mag_v = row.y1[ROW_W-1] ? ROW_W'(-row.y1) : ROW_W'(row.y1);
		den   = row.y2[DEN_W-1:0];
		init.neg_u = row.y0[ROW_W-1];
		init.neg_v = row.y1[ROW_W-1];
		init.ovf_u = {{DIV_STEPS{1'b0}}, mag_u} >= {1'b0, den, {DIV_STEPS{1'b0}}};
		init.ovf_v = {{DIV_STEPS{1'b0}}, mag_v} >= {1'b0, den, {DIV_STEPS{1'b0}}};
		init.rem_u = mag_u;
		init.rem_v = mag_v;
		init.den   = den;
		init.q_u   = '0;
		init.q_v   = '0;
		init.grem  = {row.x, {COL_STEPS{1'b0}}} - {{COL_STEPS{1'b0}}, row.x};
		init.gq    = '0;
		init.rzero = (range == '0);
	end

	always_ff @(posedge clk) begin
		if (adv[0]) dw_s[0] <= init;
	end

	for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_step
		localparam int K = DIV_STEPS - j;
		div_word_t           prv, nxt;
		logic [CMP_W-1:0]    sh_u, sh_v;
		logic [COL_STEPS-1:0] gq_n;
		logic [G_W-1:0]      grem_n;

		assign prv = dw_s[j-1];

		if (j <= COL_STEPS) begin : g_col
			localparam int KC = COL_STEPS - j;
			logic [GCMP_W-1:0] sh_c;
			always_comb begin
				sh_c   = GCMP_W'(range) << KC;
				gq_n   = prv.gq;
				grem_n = prv.grem;
				if (GCMP_W'(prv.grem) >= sh_c) begin
					grem_n   = prv.grem - sh_c[G_W-1:0];
					gq_n[KC] = 1'b1;
				end
			end
		end else begin : g_hold
			assign gq_n   = prv.gq;
			assign grem_n = prv.grem;
		end

		always_comb begin
			nxt  = prv;
			sh_u = CMP_W'(prv.den) << K;
			sh_v = sh_u;
			if (CMP_W'(prv.rem_u) >= sh_u) begin
				nxt.rem_u  = prv.rem_u - sh_u[ROW_W-1:0];
				nxt.q_u[K] = 1'b1;
			end
			if (CMP_W'(prv.rem_v) >= sh_v) begin
				nxt.rem_v  = prv.rem_v - sh_v[ROW_W-1:0];
				nxt.q_v[K] = 1'b1;
			end
			nxt.gq   = gq_n;
			nxt.grem = grem_n;
		end

		always_ff @(posedge clk) begin
			if (adv[j]) dw_s[j] <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s  <= '0;
			ovld_q <= 1'b0;
		end else begin
			if (adv[0]) vld_s[0] <= row_valid;
			for (int j = 1; j <= DIV_STEPS; j++) begin
				if (adv[j]) vld_s[j] <= vld_s[j-1];
			end
			if (adv[DIV_STEPS+1]) ovld_q <= vld_s[DIV_STEPS];
		end
	end

	// output register: saturation, red from the green remainder
	always_ff @(posedge clk) begin
		if (adv[DIV_STEPS+1]) begin
			u_q <= sat_q(dw_s[DIV_STEPS].neg_u, dw_s[DIV_STEPS].ovf_u, dw_s[DIV_STEPS].q_u);
			v_q <= sat_q(dw_s[DIV_STEPS].neg_v, dw_s[DIV_STEPS].ovf_v, dw_s[DIV_STEPS].q_v);
			if (dw_s[DIV_STEPS].rzero) begin
				red_q   <= '0;
				green_q <= '0;
			end else begin
				green_q <= dw_s[DIV_STEPS].gq;
				red_q   <= COL_FULL - dw_s[DIV_STEPS].gq
					- {7'b0, |dw_s[DIV_STEPS].grem};
			end
		end
	end

	assign pix_valid = ovld_q;
	assign pix_u     = u_q;
	assign pix_v     = v_q;
	assign pix_red   = red_q;
	assign pix_green = green_q;

endmodule

[rtl/lidar_point_to_pixel_projection.sv]
// Top level: configuration registers, matrix stages and division stages.
//
// Projects lidar points (x, y, z in signed 1/1024 m) onto the camera image
// through a configured 3x4 Q16.16 matrix and colours them by distance. One
// point word is taken every unstalled cycle; a kept point leaves as one
// pixel word after three matrix stages, one divider setup stage, sixteen
// restoring divide stages at one quotient bit each and one output register.
// Points with negative x, x above max_range or a non-positive depth are
// dropped and give no output word. Each stage advances when it is empty or
// the next one advances, so bubbles left by dropped points are squeezed out
// while the output is stalled. The user must write registers only while the
// block holds no point in flight; the block itself does not enforce it.
module lidar_point_to_pixel_projection import lp2p_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration
	input  logic                   cfg_we,
	input  logic [2:0]             cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	// point words
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic signed [PT_W-1:0] point_x,
	input  logic signed [PT_W-1:0] point_y,
	input  logic signed [PT_W-1:0] point_z,
	// pixel words
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic signed [15:0]     pixel_u,
	output logic signed [15:0]     pixel_v,
	output logic [7:0]             red,
	output logic [7:0]             green
);

	coef_set_t           coef_q;
	logic [RANGE_W-1:0]  range_q;

	logic                take;
	logic                row_valid;
	logic                row_take;
	row_word_t           row;

	// register file; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q  <= '0;
			range_q <= RANGE_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_ROW0_01:   coef_q[0] <= cfg_data;
				REG_ROW0_23:   coef_q[1] <= cfg_data;
				REG_ROW1_01:   coef_q[2] <= cfg_data;
				REG_ROW1_23:   coef_q[3] <= cfg_data;
				REG_ROW2_01:   coef_q[4] <= cfg_data;
				REG_ROW2_23:   coef_q[5] <= cfg_data;
				REG_MAX_RANGE: range_q   <= cfg_data[RANGE_W-1:0];
				default:       ;
			endcase
		end
	end

	// matrix rows: Yr = c0*x + c1*y + c2*z + c3*1024
	lp2p_rows u_rows (
		.clk       (clk),
		.arst_n    (arst_n),
		.pt_valid  (in_valid),
		.take      (take),
		.px        (point_x),
		.py        (point_y),
		.pz        (point_z),
		.coef      (coef_q),
		.range     (range_q),
		.row_valid (row_valid),
		.row       (row),
		.row_take  (row_take)
	);

	assign in_stall = !take;

	// u = Y0/Y2, v = Y1/Y2, green = 255*x/range, red from its remainder
	lp2p_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.row_valid (row_valid),
		.row       (row),
		.row_take  (row_take),
		.range     (range_q),
		.pix_valid (out_valid),
		.pix_stall (out_stall),
		.pix_u     (pixel_u),
		.pix_v     (pixel_v),
		.pix_red   (red),
		.pix_green (green)
	);

	// with the output side free every stage advances, so input never stalls
	a_no_stall_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output side is free");

	// red and green split the full scale, less one if inexact, or are both zero
	a_colour_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((9'(red) + 9'(green)) == 9'd255 ||
			(9'(red) + 9'(green)) == 9'd254 || (red == 8'd0 && green == 8'd0)))
		else $error("colour pair inconsistent");

endmodule

[tb/lidar_point_to_pixel_projection_tb.sv]
// Testbench for the lidar point to pixel projection block.
module lidar_point_to_pixel_projection_tb;
	import lp2p_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Index past the last register; a write there must be ignored.
	localparam logic [2:0] REG_SPARE = 3'd7;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 30;    // pipeline is 21 deep

	// Camera constants in Q16.16 (focal lengths, principal point, mount height).
	localparam logic [31:0] FX_Q  = 32'd30164071;
	localparam logic [31:0] FY_Q  = 32'd30036990;
	localparam logic [31:0] CX_Q  = 32'd33720598;
	localparam logic [31:0] CY_Q  = 32'd17652869;
	localparam logic [31:0] HGT_Q = 32'd6307738;
	localparam logic [31:0] ONE_Q = 32'h0001_0000;

	typedef struct {
		logic signed [15:0] u;
		logic signed [15:0] v;
		logic [7:0]         r;
		logic [7:0]         g;
	} pixel_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic signed [PT_W-1:0] point_x, point_y, point_z;
	logic out_valid;
	logic out_stall;
	logic signed [15:0] pixel_u, pixel_v;
	logic [7:0] red, green;

	lidar_point_to_pixel_projection dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.pixel_u(pixel_u), .pixel_v(pixel_v), .red(red), .green(green)
	);

	// Shadow copy of the registers, kept in step with every write.
	logic [CFG_W-1:0]   mat_shadow [NUM_COEF];
	logic [RANGE_W-1:0] range_shadow;

	pixel_t pixel_queue[$];   // pixels owed by the block, oldest first
	int errors;
	int points_sent;
	int pixels_seen;
	int configs_done;
	bit idle_on;              // random gaps on both sides
	int hold_cycles;          // long receiver hold-off, counted down below
	int rx_wait;
	int quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ---------------- prediction ----------------

	function automatic longint row_dot(input int row, input longint x, input longint y,
			input longint z);
		longint c0, c1, c2, c3;
		c0 = $signed(mat_shadow[2*row][31:0]);
		c1 = $signed(mat_shadow[2*row][63:32]);
		c2 = $signed(mat_shadow[2*row+1][31:0]);
		c3 = $signed(mat_shadow[2*row+1][63:32]);
		return c0 * x + c1 * y + c2 * z + c3 * 1024;
	endfunction

	function automatic logic signed [15:0] clamp16(input longint q);
		if (q > 32767)
			return PIX_MAX;
		if (q < -32768)
			return PIX_MIN;
		return q[15:0];
	endfunction

	// Returns 1 when the point is kept, with the pixel it maps to.
	function automatic bit project_point(input logic signed [PT_W-1:0] px,
			input logic signed [PT_W-1:0] py, input logic signed [PT_W-1:0] pz,
			output pixel_t pix);
		longint x, y, z, rng, depth, scale, rc, gc;
		x = px;
		y = py;
		z = pz;
		rng = longint'(range_shadow);
		pix = '{default: 0};
		if (x < 0 || x > rng)
			return 1'b0;
		depth = row_dot(2, x, y, z);
		if (depth <= 0)
			return 1'b0;
		// SV integer division truncates toward zero
		pix.u = clamp16(row_dot(0, x, y, z) / depth);
		pix.v = clamp16(row_dot(1, x, y, z) / depth);
		scale = rng > 0 ? rng : 1;
		rc = (255 * (rng - x)) / scale;
		gc = (255 * x) / scale;
		pix.r = rc > 255 ? COL_FULL : rc[7:0];
		pix.g = gc > 255 ? COL_FULL : gc[7:0];
		return 1'b1;
	endfunction

	// ---------------- checking ----------------

	task automatic report_mismatch(input string what, input longint got, input longint want);
		errors++;
		$display("[%0t] MISMATCH %s: got %0d expected %0d", $realtime, what, got, want);
	endtask

	// Each accepted pixel word is matched against the oldest prediction.
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && out_valid && !out_stall) begin
			pixels_seen++;
			rx_wait = idle_on ? $urandom_range(0, 3) : 0;
			if (pixel_queue.size() == 0) begin
				report_mismatch("unexpected pixel word, pending count", 1, 0);
			end else begin
				want = pixel_queue.pop_front();
				if (pixel_u !== want.u) report_mismatch("pixel_u", pixel_u, want.u);
				if (pixel_v !== want.v) report_mismatch("pixel_v", pixel_v, want.v);
				if (red !== want.r)     report_mismatch("red", red, want.r);
				if (green !== want.g)   report_mismatch("green", green, want.g);
			end
		end
	end

	// Receiver: a long hold-off when asked, else a short random wait per word.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_stall = 1'b1;
				hold_cycles--;
			end else if (rx_wait > 0) begin
				out_stall = 1'b1;
				rx_wait--;
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	// Watchdog: too long with no word moving on either side ends the run.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[%0t] timeout: no traffic, %0d pixels outstanding",
				$realtime, pixel_queue.size());
			$display("Verification failed");
			$finish;
		end
	end

	// ---------------- driving ----------------

	// Offer one point word; predict on acceptance.
	task automatic send_point(input logic signed [PT_W-1:0] x,
			input logic signed [PT_W-1:0] y, input logic signed [PT_W-1:0] z);
		int gap;
		pixel_t pix;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		in_valid = 1'b0;
		repeat (gap) @(negedge clk);
		in_valid = 1'b1;
		point_x = x;
		point_y = y;
		point_z = z;
		do @(posedge clk); while (in_stall);
		if (project_point(x, y, z, pix))
			pixel_queue.insert(pixel_queue.size(), pix);
		points_sent++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// Wait for every owed pixel, then let dropped points clear the pipe.
	task automatic drain();
		while (pixel_queue.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		configs_done++;
		if (idx == REG_MAX_RANGE)
			range_shadow = data[RANGE_W-1:0];
		else if (idx != REG_SPARE)
			mat_shadow[idx] = data;
	endtask

	// Rows are given as {entry3, entry2, entry1, entry0}.
	task automatic set_matrix(input logic [127:0] r0, input logic [127:0] r1,
			input logic [127:0] r2, input logic [RANGE_W-1:0] rng);
		drain();
		write_reg(REG_ROW0_01, r0[63:0]);
		write_reg(REG_ROW0_23, r0[127:64]);
		write_reg(REG_ROW1_01, r1[63:0]);
		write_reg(REG_ROW1_23, r1[127:64]);
		write_reg(REG_ROW2_01, r2[63:0]);
		write_reg(REG_ROW2_23, r2[127:64]);
		write_reg(REG_MAX_RANGE, CFG_W'(rng));
	endtask

	// Pinhole camera looking along +x; depth gets a small offset.
	task automatic set_camera(input logic [RANGE_W-1:0] rng, input logic [31:0] depth_ofs);
		set_matrix({32'd0, 32'd0, -FX_Q, CX_Q},
			{HGT_Q, -FY_Q, 32'd0, CY_Q},
			{depth_ofs, 32'd0, 32'd0, ONE_Q}, rng);
	endtask

	function automatic logic [31:0] rand_coef();
		case ($urandom_range(0, 3))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [PT_W-1:0] rand_coord();
		return PT_W'($urandom);
	endfunction

	// Mostly points inside the range so most reach the divider.
	task automatic send_random_point();
		logic signed [PT_W-1:0] x, y, z;
		if ($urandom_range(0, 99) < 85) begin
			x = PT_W'($urandom_range(0, range_shadow));
			y = PT_W'($signed($urandom_range(0, 40000)) - 20000);
			z = PT_W'($signed($urandom_range(0, 8000)) - 4000);
			if ($urandom_range(0, 9) == 0) y = rand_coord();
			if ($urandom_range(0, 9) == 0) z = rand_coord();
		end else begin
			x = rand_coord();
			y = rand_coord();
			z = rand_coord();
		end
		send_point(x, y, z);
	endtask

	// ---------------- tests ----------------

	// Zero matrix after reset: depth is zero, so every point is dropped.
	task automatic test_reset_state();
		send_point(20'sd0, 20'sd0, 20'sd0);
		send_point(20'sd1000, 20'sd500, -20'sd500);
		send_point(20'sd61440, 20'sd0, 20'sd0);
		send_point(20'sd61441, 20'sd0, 20'sd0);
		drain();
	endtask

	task automatic test_directed_points();
		set_camera(19'd61440, 32'd0);
		send_point(20'sd0, 20'sd0, 20'sd0);           // zero depth
		send_point(20'sd1, 20'sd0, 20'sd0);           // nearest kept
		send_point(20'sd61440, 20'sd0, 20'sd0);       // at range
		send_point(20'sd61441, 20'sd0, 20'sd0);       // just beyond range
		send_point(-20'sd1, 20'sd0, 20'sd0);          // behind sensor
		send_point(-20'sd524288, 20'sd0, 20'sd0);
		send_point(20'sd524287, 20'sd0, 20'sd0);
		send_point(20'sd1, 20'sd524287, 20'sd524287); // saturate low
		send_point(20'sd1, -20'sd524288, -20'sd524288); // saturate high
		send_point(20'sd10240, 20'sd1024, -20'sd2048);
		send_point(20'sd30720, -20'sd3000, 20'sd700);
		send_point(20'sd5000, 20'sd524287, -20'sd524288);
		// full-scale coefficients and range
		set_matrix({32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000},
			{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff},
			{32'h7fff_ffff, 32'h0000_0001, 32'hffff_ffff, 32'h7fff_ffff}, 19'h7ffff);
		send_point(20'sd524287, 20'sd524287, 20'sd524287);
		send_point(20'sd524287, -20'sd524288, -20'sd524288);
		send_point(20'sd0, 20'sd0, 20'sd0);
		send_point(20'sd262144, -20'sd1, 20'sd1);
		send_point(20'sd1, -20'sd524288, 20'sd524287);
		drain();
	endtask

	// Range register at zero and at one.
	task automatic test_small_ranges();
		set_camera(19'd0, ONE_Q);
		send_point(20'sd0, 20'sd100, 20'sd100);       // only x = 0 survives
		send_point(20'sd1, 20'sd100, 20'sd100);
		send_point(20'sd0, -20'sd524288, 20'sd524287);
		set_camera(19'd1, ONE_Q);
		send_point(20'sd0, 20'sd5, -20'sd5);
		send_point(20'sd1, 20'sd5, -20'sd5);
		send_point(20'sd2, 20'sd5, -20'sd5);
		drain();
	endtask

	// A write past the last register must leave the setup unchanged.
	task automatic test_spare_index();
		set_camera(19'd61440, 32'd0);
		write_reg(REG_SPARE, {CFG_W{1'b1}});
		repeat (6) send_point(PT_W'($urandom_range(1, 61440)), rand_coord(), rand_coord());
		drain();
	endtask

	// Random setups, each followed by a batch of points.
	task automatic test_random_setups(input int phases, input int per_phase);
		logic [RANGE_W-1:0] rng;
		for (int p = 0; p < phases; p++) begin
			case ($urandom_range(0, 4))
				0: rng = 19'd1;
				1: rng = 19'h7ffff;
				2: rng = 19'd61440;
				default: rng = RANGE_W'($urandom_range(1, 524287));
			endcase
			if ($urandom_range(0, 2) != 0)
				set_camera(rng, $urandom_range(0, 131072));
			else
				set_matrix({rand_coef(), rand_coef(), rand_coef(), rand_coef()},
					{rand_coef(), rand_coef(), rand_coef(), rand_coef()},
					{rand_coef(), rand_coef(), rand_coef(), rand_coef()}, rng);
			idle_on = (p % 3) != 2;   // every third phase runs gap-free
			repeat (per_phase) send_random_point();
		end
		idle_on = 1'b1;
		drain();
	endtask

	// Receiver holds off long enough that the pipe fills and stalls the input.
	task automatic test_backpressure();
		set_camera(19'd61440, ONE_Q);
		idle_on = 1'b0;
		hold_cycles = 200;
		repeat (60) send_point(PT_W'($urandom_range(0, 61440)),
			PT_W'($signed($urandom_range(0, 8000)) - 4000), rand_coord());
		idle_on = 1'b1;
		drain();      // sender pauses until the last owed pixel is out
		repeat (20) send_random_point();
		drain();
	endtask

	initial begin
		errors = 0;
		points_sent = 0;
		pixels_seen = 0;
		configs_done = 0;
		idle_on = 1'b1;
		hold_cycles = 0;
		rx_wait = 0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		point_x = '0;
		point_y = '0;
		point_z = '0;
		foreach (mat_shadow[i]) mat_shadow[i] = '0;
		range_shadow = RANGE_RESET;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_state();
		test_directed_points();
		test_small_ranges();
		test_spare_index();
		test_backpressure();
		test_random_setups(6, 95);

		drain();
		$display("Run covered %0d points, %0d pixels checked, %0d register writes,",
			points_sent, pixels_seen, configs_done);
		$display("including zero/unit/full range, full-scale matrices and a long output hold.");
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[filelist.f]
rtl/lp2p_pkg.sv
rtl/lp2p_rows.sv
rtl/lp2p_div.sv
rtl/lidar_point_to_pixel_projection.sv
tb/lidar_point_to_pixel_projection_tb.sv
